/* rtl/api_frame_receive_parser_assert.svh */
// assertion helpers for the api frame receive parser
// clk and rst are the clock and synchronous reset of the module that uses them
`ifndef API_FRAME_RECEIVE_PARSER_ASSERT_SVH
`define API_FRAME_RECEIVE_PARSER_ASSERT_SVH

// same-cycle implication
`define AFRP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afrp assertion failed");

// next-cycle implication
`define AFRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afrp assertion failed");

`endif

/* rtl/afrp_pkg.sv */
package afrp_pkg;

  localparam int TailBytesDefault = 8;

  localparam logic [7:0]  StartByte         = 8'h7E;
  localparam logic [15:0] HeaderAfterLength = 16'h000C;
  localparam logic [7:0]  ChecksumBase      = 8'hFF;
  localparam logic [15:0] MaxPayload        = 16'd65523;
  localparam logic [15:0] LenBytes          = 16'd2;
  localparam logic [15:0] AddrBytes         = 16'd8;
  localparam logic [15:0] NetBytes          = 16'd2;

  typedef enum logic [7:0] {
    PhHunt    = 8'b0000_0001,
    PhLen     = 8'b0000_0010,
    PhKind    = 8'b0000_0100,
    PhAddr    = 8'b0000_1000,
    PhNet     = 8'b0001_0000,
    PhOpt     = 8'b0010_0000,
    PhPayload = 8'b0100_0000,
    PhCheck   = 8'b1000_0000
  } afrp_phase_t;

  typedef struct packed {
    logic        checksum_good;
    logic [7:0]  frame_kind;
    logic [63:0] source_address;
    logic [15:0] payload_count;
    logic [63:0] payload_tail;
  } afrp_result_t;

  function automatic logic [15:0] payload_len(input logic [15:0] frame_length);
    logic [15:0] len;
    len = (frame_length >= HeaderAfterLength) ? (frame_length - HeaderAfterLength) : 16'd0;
    return len;
  endfunction

endpackage

/* rtl/afrp_parser.sv */
module afrp_parser #(
  parameter int TAIL_BYTES = afrp_pkg::TailBytesDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  output logic                  in_check,
  output afrp_pkg::afrp_result_t result
);
  import afrp_pkg::*;

  `include "api_frame_receive_parser_assert.svh"

  localparam int TailW = TAIL_BYTES * 8;

  afrp_phase_t       phase;
  logic [15:0]       bytes_left;
  logic [15:0]       frame_length;
  logic [7:0]        running_sum;
  logic [7:0]        kind_reg;
  logic [63:0]       address_reg;
  logic [TailW-1:0]  payload_reg;
  logic [7:0]        running_sum_next;
  logic [15:0]       len_now;

  assign running_sum_next = running_sum + rx_byte;
  assign len_now          = payload_len(frame_length);
  assign in_check         = (phase == PhCheck);

  always_comb begin
    result.checksum_good  = (rx_byte == (ChecksumBase - running_sum));
    result.frame_kind     = kind_reg;
    result.source_address = address_reg;
    result.payload_count  = len_now;
    result.payload_tail   = 64'(payload_reg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PhHunt;
      bytes_left   <= 16'd0;
      frame_length <= 16'd0;
      running_sum  <= 8'd0;
      kind_reg     <= 8'd0;
      address_reg  <= 64'd0;
      payload_reg  <= '0;
    end else if (accept) begin
      case (phase)
        PhHunt: begin
          if (rx_byte == StartByte) begin
            phase       <= PhLen;
            bytes_left  <= LenBytes;
            payload_reg <= '0;
          end
        end
        PhLen: begin
          frame_length <= {frame_length[7:0], rx_byte};
          bytes_left   <= bytes_left - 16'd1;
          if (bytes_left == 16'd1) begin
            phase <= PhKind;
          end
        end
        PhKind: begin
          kind_reg    <= rx_byte;
          running_sum <= rx_byte;
          phase       <= PhAddr;
          bytes_left  <= AddrBytes;
        end
        PhAddr: begin
          running_sum <= running_sum_next;
          address_reg <= {address_reg[55:0], rx_byte};
          bytes_left  <= bytes_left - 16'd1;
          if (bytes_left == 16'd1) begin
            phase      <= PhNet;
            bytes_left <= NetBytes;
          end
        end
        PhNet: begin
          running_sum <= running_sum_next;
          bytes_left  <= bytes_left - 16'd1;
          if (bytes_left == 16'd1) begin
            phase <= PhOpt;
          end
        end
        PhOpt: begin
          running_sum <= running_sum_next;
          bytes_left  <= len_now;
          phase       <= (len_now == 16'd0) ? PhCheck : PhPayload;
        end
        PhPayload: begin
          running_sum <= running_sum_next;
          payload_reg <= TailW'({payload_reg, rx_byte});
          bytes_left  <= bytes_left - 16'd1;
          if (bytes_left == 16'd1) begin
            phase <= PhCheck;
          end
        end
        PhCheck: begin
          phase      <= PhHunt;
          bytes_left <= 16'd0;
        end
        default: begin
          phase      <= PhHunt;
          bytes_left <= 16'd0;
        end
      endcase
    end
  end

  `AFRP_ASSERT_IMPL(a_payload_left, phase == PhPayload, bytes_left != 16'd0)
  `AFRP_ASSERT_IMPL(a_len_left, phase == PhLen, bytes_left == 16'd1 || bytes_left == 16'd2)
  `AFRP_ASSERT_IMPL(a_addr_left, phase == PhAddr, bytes_left >= 16'd1 && bytes_left <= AddrBytes)

endmodule

/* rtl/api_frame_receive_parser.sv */
// output: a result appears on the outputs in the cycle after its checksum word is accepted
// throughput: one word per cycle; input stalls only when a result waits and the next
//   word is a checksum word
// reset: synchronous, clears the parser to hunting for the start word and drops any
//   pending result
module api_frame_receive_parser #(
  parameter int TAIL_BYTES = afrp_pkg::TailBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        checksum_good,
  output logic [7:0]  frame_kind,
  output logic [63:0] source_address,
  output logic [15:0] payload_count,
  output logic [63:0] payload_tail
);
  import afrp_pkg::*;

  `include "api_frame_receive_parser_assert.svh"

  logic         accept;
  logic         in_check;
  afrp_result_t result;
  afrp_result_t result_q;

  assign in_ready = !in_check || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  afrp_parser #(
    .TAIL_BYTES(TAIL_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .in_check (in_check),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_check) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_check) begin
      result_q <= result;
    end
  end

  assign checksum_good  = result_q.checksum_good;
  assign frame_kind     = result_q.frame_kind;
  assign source_address = result_q.source_address;
  assign payload_count  = result_q.payload_count;
  assign payload_tail   = result_q.payload_tail;

  `AFRP_ASSERT_IMPL(a_rise_from_check, $rose(out_valid), $past(accept && in_check))
  `AFRP_ASSERT_IMPL(a_no_overwrite, out_valid && !out_ready, !(accept && in_check))
  `AFRP_ASSERT_IMPL(a_count_range, out_valid, payload_count <= MaxPayload)

endmodule
